### hw/rtl/akd_pkg.sv
// ----------------------------------------------------------------------------
// akd_pkg
// Types and constants shared by the autokey byte decipher blocks.
// ----------------------------------------------------------------------------
package akd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] key_type;
   typedef logic [4:0]  step_type;

   localparam key_type  KEY_RESET  = 32'd1172968056;
   localparam step_type STEP_LIMIT = 5'd16;

   typedef struct packed {
      byte_type plain;
      key_type  key;
      step_type step;
   } step_out_type;

endpackage

### hw/rtl/akd_req_if.sv
// ----------------------------------------------------------------------------
// akd_req_if
// Cipher word channel: valid/ready with one byte and a block end flag.
// ----------------------------------------------------------------------------
interface akd_req_if
   import akd_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type cipher_byte;
   logic     block_last;

   modport source (output valid, output cipher_byte, output block_last, input ready);
   modport sink   (input valid, input cipher_byte, input block_last, output ready);
endinterface

### hw/rtl/akd_rsp_if.sv
// ----------------------------------------------------------------------------
// akd_rsp_if
// Plain word channel: valid/ready with one byte and a block end flag.
// ----------------------------------------------------------------------------
interface akd_rsp_if
   import akd_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type plain_byte;
   logic     result_last;

   modport source (output valid, output plain_byte, output result_last, input ready);
   modport sink   (input valid, input plain_byte, input result_last, output ready);
endinterface

### hw/rtl/akd_key_step.sv
// ----------------------------------------------------------------------------
// akd_key_step
// One autokey step: keystream byte, plain byte and next key/step count.
// ----------------------------------------------------------------------------
module akd_key_step
   import akd_pkg::*;
(
   input  key_type      key_state,
   input  step_type     step_count,
   input  byte_type     cipher_byte,
   output step_out_type step_out
);

   byte_type    keystream;
   byte_type    plain;
   logic [63:0] spun_wide;
   key_type     spun;
   key_type     mixed;
   key_type     turned;

   always_comb begin
      keystream = key_state[7:0] + key_state[15:8] + key_state[23:16] + key_state[31:24];
      plain     = cipher_byte ^ keystream;
      spun_wide = {key_state, key_state} << plain[4:0];
      spun      = spun_wide[63:32];
      mixed     = spun + {4{plain}};
      turned    = {mixed[30:0], mixed[31]};

      step_out.plain = plain;
      if (step_count > STEP_LIMIT) begin
         step_out.key  = {turned[30:0], 1'b0};
         step_out.step = 5'd1;
      end else begin
         step_out.key  = turned;
         step_out.step = step_count + 5'd1;
      end
   end

endmodule

### hw/rtl/autokey_byte_stream_decipher_core.sv
// ----------------------------------------------------------------------------
// autokey_byte_stream_decipher_core
// Deciphers a byte stream against a self-updating 32-bit autokey state.
// ----------------------------------------------------------------------------
//  channel   | direction | word
//  req_chan  | in        | cipher_byte[7:0], block_last
//  rsp_chan  | out       | plain_byte[7:0], result_last
//  csr_*     | in        | csr_wdata[31:0] -> initial_key
//
//  One word per cycle unless rsp stalls; words pass input then result register.
//  The rate is set by the key update loop: one key step per cycle.
//  Reset loads key and initial_key with the default key, empties both stages.
//  A stall on rsp holds the result register; req_ready drops only when the
//  input register is full and cannot advance.
// ----------------------------------------------------------------------------
module autokey_byte_stream_decipher_core
   import akd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   akd_req_if.sink    req_chan,
   akd_rsp_if.source  rsp_chan,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  key_type    csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   byte_type     in_cipher_ff, in_cipher_in;
   logic         in_last_ff, in_last_in;
   logic         out_valid_ff, out_valid_in;
   byte_type     out_plain_ff, out_plain_in;
   logic         out_last_ff, out_last_in;
   key_type      key_state_ff, key_state_in;
   step_type     step_count_ff, step_count_in;
   key_type      initial_key_ff, initial_key_in;
   logic         advance;
   logic         take_req;
   step_out_type step_out;

   akd_key_step u_key_step (
      .key_state   (key_state_ff),
      .step_count  (step_count_ff),
      .cipher_byte (in_cipher_ff),
      .step_out    (step_out)
   );

   assign advance          = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || advance;
   assign take_req         = req_chan.valid && req_chan.ready;
   assign csr_ready        = 1'b1;
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.plain_byte  = out_plain_ff;
   assign rsp_chan.result_last = out_last_ff;

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_cipher_in   = in_cipher_ff;
      in_last_in     = in_last_ff;
      out_valid_in   = out_valid_ff;
      out_plain_in   = out_plain_ff;
      out_last_in    = out_last_ff;
      key_state_in   = key_state_ff;
      step_count_in  = step_count_ff;
      initial_key_in = initial_key_ff;

      if (csr_valid) begin
         initial_key_in = csr_wdata;
      end

      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_plain_in = step_out.plain;
         out_last_in  = in_last_ff;
         if (in_last_ff) begin
            key_state_in  = initial_key_ff;
            step_count_in = '0;
         end else begin
            key_state_in  = step_out.key;
            step_count_in = step_out.step;
         end
      end
      if (take_req) begin
         in_valid_in  = 1'b1;
         in_cipher_in = req_chan.cipher_byte;
         in_last_in   = req_chan.block_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         key_state_ff   <= KEY_RESET;
         step_count_ff  <= '0;
         initial_key_ff <= KEY_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         key_state_ff   <= key_state_in;
         step_count_ff  <= step_count_in;
         initial_key_ff <= initial_key_in;
      end
   end

   always_ff @(posedge clock) begin
      in_cipher_ff <= in_cipher_in;
      in_last_ff   <= in_last_in;
      out_plain_ff <= out_plain_in;
      out_last_ff  <= out_last_in;
   end

`ifndef ASSERT_OFF
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_count_ff <= STEP_LIMIT + 5'd1)
      else $error("step count beyond limit");

   a_block_reload: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> key_state_ff == $past(initial_key_ff) && step_count_ff == '0)
      else $error("key not reloaded at block end");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register not loaded");

   a_key_holds: assert property (@(posedge clock) disable iff (reset)
      !reset && !advance |=> $stable(key_state_ff) && $stable(step_count_ff))
      else $error("key changed without a word");
`endif

endmodule

### dv/akd_decipher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// akd_decipher_checker
// Watches the cipher, plain and key write channels of the decipher core,
// works out the plain word due for every accepted cipher word from its own
// copy of the autokey state, and compares each accepted plain word in order.
// ----------------------------------------------------------------------------
module akd_decipher_checker
   import akd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   akd_req_if      req_mon,
   akd_rsp_if      rsp_mon,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  key_type csr_wdata,
   output int      outstanding,
   output int      fail_count,
   output int      doublings
);

   typedef struct packed {
      byte_type plain;
      logic     last;
   } plain_word_type;

   plain_word_type plain_q[$];
   key_type        start_key;
   key_type        run_key;
   step_type       run_step;

   initial begin
      fail_count  = 0;
      doublings   = 0;
      outstanding = 0;
   end

   function automatic key_type rotl32(key_type v, int unsigned n);
      n = n % 32;
      return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
   endfunction

   function automatic byte_type decipher_step(byte_type cipher, logic last);
      byte_type ks;
      byte_type plain;
      key_type  nxt;
      ks    = run_key[7:0] + run_key[15:8] + run_key[23:16] + run_key[31:24];
      plain = cipher ^ ks;
      nxt   = rotl32(rotl32(run_key, plain[4:0]) + {4{plain}}, 1);
      if (run_step > STEP_LIMIT) begin
         nxt      = nxt << 1;
         run_step = '0;
         doublings++;
      end
      run_step = run_step + 1'b1;
      run_key  = nxt;
      if (last) begin
         run_key  = start_key;
         run_step = '0;
      end
      return plain;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (fail_count < 50)
         $display("%0t: mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      plain_word_type w;
      if (reset) begin
         plain_q.delete();
         start_key   = KEY_RESET;
         run_key     = KEY_RESET;
         run_step    = '0;
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (plain_q.size() == 0) begin
               report_mismatch("word with none due", rsp_mon.plain_byte, 0);
            end else begin
               w = plain_q.pop_front();
               if (rsp_mon.plain_byte !== w.plain)
                  report_mismatch("plain_byte", rsp_mon.plain_byte, w.plain);
               if (rsp_mon.result_last !== w.last)
                  report_mismatch("result_last", rsp_mon.result_last, w.last);
            end
         end
         if (csr_valid && csr_ready)
            start_key = csr_wdata;
         if (req_mon.valid && req_mon.ready) begin
            w.plain = decipher_step(req_mon.cipher_byte, req_mon.block_last);
            w.last  = req_mon.block_last;
            plain_q.push_back(w);
         end
         outstanding <= plain_q.size();
      end
   end

endmodule

### dv/tb_autokey_byte_stream_decipher_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_autokey_byte_stream_decipher_core
// Drives cipher words and initial key writes into the decipher core under
// varying source idling and sink stalls; the checker beside the core
// predicts every plain word and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_autokey_byte_stream_decipher_core;
   import akd_pkg::*;

   logic    clock;
   logic    reset;
   logic    csr_valid;
   logic    csr_ready;
   key_type csr_wdata;

   int outstanding;
   int fail_count;
   int doublings;
   int src_idle_pct;
   int snk_stall_pct;
   int words_sent;
   int blocks_ended;
   int key_writes;
   int blk_left;

   akd_req_if req_bus ();
   akd_rsp_if rsp_bus ();

   autokey_byte_stream_decipher_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   akd_decipher_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count),
      .doublings   (doublings)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
   end

   task automatic send_word(byte_type cipher, logic last);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cipher_byte <= cipher;
      req_bus.block_last  <= last;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
      if (last)
         blocks_ended++;
   endtask

   // hold off until every plain word due has come back
   task automatic drain;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_key(key_type value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      key_writes++;
   endtask

   task automatic run_phase(int n_words, int idle_pct, int stall_pct);
      logic last;
      src_idle_pct  = idle_pct;
      snk_stall_pct = stall_pct;
      for (int i = 0; i < n_words; i++) begin
         if (blk_left == 0)
            blk_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                   : $urandom_range(10, 60);
         last = (blk_left == 1);
         blk_left--;
         send_word(byte_type'($urandom_range(0, 255)), last);
      end
      drain();
   endtask

   initial begin
      #(4_000_000);
      $display("tb_autokey_byte_stream_decipher_core NOT OK");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.cipher_byte = '0;
      req_bus.block_last  = 1'b0;
      rsp_bus.ready       = 1'b0;
      src_idle_pct        = 0;
      snk_stall_pct       = 0;
      words_sent          = 0;
      blocks_ended        = 0;
      key_writes          = 0;
      blk_left            = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default key: extreme bytes, then a key write in mid block
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h55, 1'b0);
      send_word(8'hAA, 1'b0);
      for (int i = 0; i < 6; i++)
         send_word(byte_type'($urandom_range(0, 255)), 1'b0);
      drain();
      write_key(32'hFFFF_FFFF);
      // run on past the step limit so the key doubles
      for (int i = 0; i < 10; i++)
         send_word(byte_type'($urandom_range(0, 255)), 1'b0);
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b1);
      drain();

      write_key(32'h0000_0000);
      run_phase(700, 35, 57);
      write_key(key_type'($urandom));
      run_phase(700, 57, 35);
      write_key(KEY_RESET);
      run_phase(300, 0, 0);
      write_key(key_type'($urandom));
      run_phase(300, 0, 0);

      repeat (8) @(posedge clock);
      $display("covered %0d cipher words in %0d blocks, %0d key writes, %0d key doublings",
               words_sent, blocks_ended, key_writes, doublings);
      $display("source idle and sink stall mixes 35/57, 57/35 and none; %0d mismatches",
               fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb_autokey_byte_stream_decipher_core OK");
      end else begin
         $display("tb_autokey_byte_stream_decipher_core NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/akd_pkg.sv
hw/rtl/akd_req_if.sv
hw/rtl/akd_rsp_if.sv
hw/rtl/akd_key_step.sv
hw/rtl/autokey_byte_stream_decipher_core.sv
dv/akd_decipher_checker.sv
dv/tb_autokey_byte_stream_decipher_core.sv
